// ----- hw/rtl/crcfb_pkg.sv -----
package crcfb_pkg;

  localparam logic [7:0]  SOF_BYTE         = 8'hA5;
  localparam logic [15:0] LINK_CMD         = 16'h0301;
  localparam logic [15:0] DEFAULT_RECEIVER = 16'h0101;
  localparam logic [15:0] RECEIVER_OFFSET  = 16'd256;
  localparam logic [7:0]  CRC8_INIT        = 8'hFF;
  localparam logic [15:0] CRC16_INIT       = 16'hFFFF;
  localparam logic [7:0]  CRC8_POLY_REV    = 8'h8C;
  localparam logic [15:0] CRC16_POLY_REV   = 16'h8408;
  localparam logic [8:0]  LEN_EXTRA        = 9'd6;
  localparam logic [3:0]  HDR_LAST_IDX     = 4'd12;
  localparam logic [3:0]  CRC8_LAST_IDX    = 4'd3;
  localparam logic [3:0]  CRC8_IDX         = 4'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] sub_command;
    logic [7:0]  payload_length;
    logic [7:0]  frame_count;
    logic [7:0]  payload_byte;
    logic        last;
  } cmd_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY_REV) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY_REV) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/crcfb_front.sv -----
module crcfb_front
  import crcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_sub_command,
  input  logic [7:0]  in_payload_length,
  input  logic [7:0]  in_payload_byte,
  input  logic        queue_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [7:0] frame_counter;
  logic [7:0] bytes_remaining;
  logic       frame_open;
  logic       accept;
  logic       is_start;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_start = (kind_t'(in_op) == KIND_START);
  assign push     = accept && (is_start || frame_open);

  always_comb begin
    push_cmd.kind           = kind_t'(in_op);
    push_cmd.sub_command    = in_sub_command;
    push_cmd.payload_length = in_payload_length;
    push_cmd.frame_count    = frame_counter;
    push_cmd.payload_byte   = in_payload_byte;
    push_cmd.last           = (bytes_remaining == 8'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter   <= 8'd0;
      bytes_remaining <= 8'd0;
      frame_open      <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        frame_counter   <= frame_counter + 8'd1;
        bytes_remaining <= in_payload_length;
        frame_open      <= (in_payload_length != 8'd0);
      end else if (frame_open) begin
        bytes_remaining <= bytes_remaining - 8'd1;
        if (bytes_remaining == 8'd1) begin
          frame_open <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/crcfb_queue.sv -----
module crcfb_queue
  import crcfb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/crcfb_back.sv -----
module crcfb_back
  import crcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] sender_id,
  input  logic        queue_empty,
  input  cmd_t        queue_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_HDR    = 4'b0010,
    ST_TRL_LO = 4'b0100,
    ST_TRL_HI = 4'b1000
  } state_t;

  state_t      state;
  cmd_t        cur;
  logic [3:0]  hdr_idx;
  logic [7:0]  crc8;
  logic [15:0] crc16;
  logic        out_free;
  logic        emit;
  logic [8:0]  data_len;
  logic [15:0] receiver_id;
  logic [7:0]  hdr_byte;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && !queue_empty && out_free;
  assign emit     = pop || (out_free && ((state == ST_HDR) || (state == ST_TRL_LO) ||
                                         (state == ST_TRL_HI)));
  assign data_len = {1'b0, cur.payload_length} + LEN_EXTRA;

  always_comb begin
    if (((sender_id >= 16'd1) && (sender_id <= 16'd7)) ||
        ((sender_id >= 16'd101) && (sender_id <= 16'd107))) begin
      receiver_id = sender_id + RECEIVER_OFFSET;
    end else begin
      receiver_id = DEFAULT_RECEIVER;
    end
  end

  always_comb begin
    case (hdr_idx)
      4'd1:    hdr_byte = data_len[7:0];
      4'd2:    hdr_byte = {7'd0, data_len[8]};
      4'd3:    hdr_byte = cur.frame_count;
      4'd4:    hdr_byte = crc8;
      4'd5:    hdr_byte = LINK_CMD[7:0];
      4'd6:    hdr_byte = LINK_CMD[15:8];
      4'd7:    hdr_byte = cur.sub_command[7:0];
      4'd8:    hdr_byte = cur.sub_command[15:8];
      4'd9:    hdr_byte = sender_id[7:0];
      4'd10:   hdr_byte = sender_id[15:8];
      4'd11:   hdr_byte = receiver_id[7:0];
      4'd12:   hdr_byte = receiver_id[15:8];
      default: hdr_byte = SOF_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            out_last <= 1'b0;
            if (queue_cmd.kind == KIND_START) begin
              cur      <= queue_cmd;
              out_byte <= SOF_BYTE;
              crc8     <= crc8_step(CRC8_INIT, SOF_BYTE);
              crc16    <= crc16_step(CRC16_INIT, SOF_BYTE);
              hdr_idx  <= 4'd1;
              state    <= ST_HDR;
            end else begin
              out_byte <= queue_cmd.payload_byte;
              crc16    <= crc16_step(crc16, queue_cmd.payload_byte);
              if (queue_cmd.last) begin
                state <= ST_TRL_LO;
              end
            end
          end
        end
        ST_HDR: begin
          if (out_free) begin
            out_last <= 1'b0;
            out_byte <= hdr_byte;
            crc16    <= crc16_step(crc16, hdr_byte);
            if (hdr_idx <= CRC8_LAST_IDX) begin
              crc8 <= crc8_step(crc8, hdr_byte);
            end
            hdr_idx <= hdr_idx + 4'd1;
            if (hdr_idx == HDR_LAST_IDX) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_TRL_LO: begin
          if (out_free) begin
            out_last <= 1'b0;
            out_byte <= crc16[7:0];
            state    <= ST_TRL_HI;
          end
        end
        ST_TRL_HI: begin
          if (out_free) begin
            out_last <= 1'b1;
            out_byte <= crc16[15:8];
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/crc_checked_frame_builder.sv -----
// channel   dir  signals                        contents
// s_axis    in   tvalid tready tdata tuser      tdata: sub_command, payload_length,
//                                               payload_byte; tuser: op
// m_axis    out  tvalid tready tdata tlast      tdata: out_byte; tlast: frame_end
// cfg       in   cfg_wr_en cfg_wr_data          sender_id
//
// a payload word leaves as one output byte; the last one adds two crc16 trailer
// bytes. a start word produces 13 header bytes at one per cycle while m_axis_tready
// holds, from the output sequencer, which sets the rate for headers.
// a four-entry command queue sits between input decode and the byte sequencer.
// rst is synchronous; sender_id resets to 1, frame counter to 0.
module crc_checked_frame_builder
  import crcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sub_command, payload_length, payload_byte
  input  logic [0:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] sender_id;
  logic        push;
  cmd_t        push_cmd;
  logic        queue_full;
  logic        pop;
  cmd_t        pop_cmd;
  logic        queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      sender_id <= 16'd1;
    end else if (cfg_wr_en) begin
      sender_id <= cfg_wr_data;
    end
  end

  crcfb_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .in_op             (s_axis_tuser[0]),
    .in_sub_command    (s_axis_tdata[15:0]),
    .in_payload_length (s_axis_tdata[23:16]),
    .in_payload_byte   (s_axis_tdata[31:24]),
    .queue_full        (queue_full),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  crcfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (queue_empty)
  );

  crcfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .sender_id   (sender_id),
    .queue_empty (queue_empty),
    .queue_cmd   (pop_cmd),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule
